// File: src/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Shared codes and controller/datapath signal groups for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

	// Request operation codes
	localparam logic [2:0] OP_INSERT_HEAD  = 3'd0;
	localparam logic [2:0] OP_INSERT_TAIL  = 3'd1;
	localparam logic [2:0] OP_REMOVE_FIRST = 3'd2;
	localparam logic [2:0] OP_REMOVE_ALL   = 3'd3;
	localparam logic [2:0] OP_FIND         = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Output count width
	localparam int OUT_CW = 5;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, arm the walk
		logic scan;    // walk the stored entries
		logic finish;  // commit and register the result
	} ols_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;  // every entry read and processed
	} ols_sts_t;

endpackage

// File: src/ols_req_if.sv
// ----------------------------------------------------------------------------
// ols_req_if
// Request channel: operation and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ols_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  operation;
	logic signed [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// File: src/ols_rsp_if.sv
// ----------------------------------------------------------------------------
// ols_rsp_if
// Result channel: status, found flag, removed count and list length.
// ----------------------------------------------------------------------------
interface ols_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	logic [4:0] removed_count;
	logic [4:0] list_length;

	modport source (output valid, output status, output found, output removed_count,
		output list_length, input ready);
	modport sink   (input valid, input status, input found, input removed_count,
		input list_length, output ready);
endinterface

// File: src/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ols_ctrl
// Sequencer: accept a request, walk the store, commit, hand over the result.
// ----------------------------------------------------------------------------
module ols_ctrl
	import ols_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ols_sts_t sts,
	output ols_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;
	localparam logic [1:0] S_RESP   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SCAN;
			S_SCAN:   if (sts.scan_done) state_d = S_FINISH;
			S_FINISH: state_d = S_RESP;
			S_RESP:   if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Handshakes and commands
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_RESP);
	assign cmd.load   = in_ready && in_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_FINISH);

endmodule

// File: src/ols_dp.sv
// ----------------------------------------------------------------------------
// ols_dp
// Datapath: entry memory, walk pointers, compare and compaction, result regs.
// ----------------------------------------------------------------------------
module ols_dp
	import ols_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ols_cmd_t           cmd,
	output ols_sts_t           sts,
	input  logic        [2:0]  req_operation,
	input  logic signed [31:0] req_value,
	output logic        [1:0]  res_status,
	output logic               res_found,
	output logic        [4:0]  res_removed_count,
	output logic        [4:0]  res_list_length
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > OUT_CW) ? CW : OUT_CW;

	// Entry memory, list order, index 0 is the head
	logic [31:0] mem [CAPACITY];

	logic [CW-1:0]      count_q;
	logic [2:0]         op_q;
	logic signed [31:0] val_q;
	logic               desc_q;
	logic [CW-1:0]      rem_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic [31:0]        rdata_s1;
	logic [CW-1:0]      w_q;
	logic [CW-1:0]      removed_q;
	logic               found_q;
	logic               done_q;

	logic          full;
	logic          ld_desc;
	logic          eq;
	logic          proc;
	logic          keep;
	logic          drop;
	logic          we_c;
	logic [AW-1:0] waddr_c;
	logic [31:0]   wdata_c;
	logic [CW-1:0] count_d;
	logic [1:0]    status_d;
	logic [XW-1:0] removed_x;
	logic [XW-1:0] length_x;

	assign full    = (count_q == CW'(CAPACITY));
	assign ld_desc = (req_operation == OP_INSERT_HEAD) && !full;
	assign proc    = cmd.scan && vld_s1;
	assign eq      = (rdata_s1 == val_q);

	// Compaction decision for the remove operations
	always_comb begin
		keep = 1'b0;
		drop = 1'b0;
		case (op_q)
			OP_REMOVE_FIRST: begin
				drop = eq && !done_q;
				keep = !drop;
			end
			OP_REMOVE_ALL: begin
				drop = eq;
				keep = !eq;
			end
			default: begin
				keep = 1'b0;
				drop = 1'b0;
			end
		endcase
	end

	// Single write port: shift during the walk, new entry at commit
	always_comb begin
		we_c    = 1'b0;
		waddr_c = '0;
		wdata_c = rdata_s1;
		if (proc && desc_q) begin
			we_c    = 1'b1;
			waddr_c = AW'(idx_s1 + 1'b1);
		end else if (proc && keep) begin
			we_c    = 1'b1;
			waddr_c = w_q[AW-1:0];
		end else if (cmd.finish && !full) begin
			if (op_q == OP_INSERT_HEAD) begin
				we_c    = 1'b1;
				waddr_c = '0;
				wdata_c = val_q;
			end else if (op_q == OP_INSERT_TAIL) begin
				we_c    = 1'b1;
				waddr_c = count_q[AW-1:0];
				wdata_c = val_q;
			end
		end
	end

	// Final count and status
	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		case (op_q)
			OP_INSERT_HEAD, OP_INSERT_TAIL: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			OP_REMOVE_FIRST, OP_REMOVE_ALL: begin
				count_d  = w_q;
				status_d = (removed_q != '0) ? ST_OK : ST_NOT_FOUND;
			end
			OP_FIND: status_d = found_q ? ST_OK : ST_NOT_FOUND;
			default: status_d = ST_OK;
		endcase
	end

	assign removed_x = XW'(removed_q);
	assign length_x  = XW'(count_d);

	// Memory and read stage
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		if (cmd.scan && rem_q != '0) begin
			rdata_s1 <= mem[rd_ptr_q];
			idx_s1   <= rd_ptr_q;
		end
	end

	// Walk control and running results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			op_q      <= OP_FIND;
			val_q     <= '0;
			desc_q    <= 1'b0;
			rem_q     <= '0;
			rd_ptr_q  <= '0;
			vld_s1    <= 1'b0;
			w_q       <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else if (cmd.load) begin
			op_q      <= req_operation;
			val_q     <= req_value;
			desc_q    <= ld_desc;
			rem_q     <= count_q;
			rd_ptr_q  <= ld_desc ? AW'(count_q - 1'b1) : '0;
			vld_s1    <= 1'b0;
			w_q       <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan && (rem_q != '0);
			if (cmd.scan && rem_q != '0) begin
				rem_q    <= rem_q - 1'b1;
				rd_ptr_q <= desc_q ? AW'(rd_ptr_q - 1'b1) : AW'(rd_ptr_q + 1'b1);
			end
			if (proc) begin
				if (eq) found_q <= 1'b1;
				if (keep) w_q <= w_q + 1'b1;
				if (drop) begin
					removed_q <= removed_q + 1'b1;
					done_q    <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q <= count_d;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status        <= status_d;
			res_found         <= found_q;
			res_removed_count <= removed_x[OUT_CW-1:0];
			res_list_length   <= length_x[OUT_CW-1:0];
		end
	end

	assign sts.scan_done = (rem_q == '0) && !vld_s1;

endmodule

// File: src/ordered_list_store_top.sv
// ----------------------------------------------------------------------------
// ordered_list_store_top
// Ordered list of signed 32-bit values with insert, remove and find requests.
// ----------------------------------------------------------------------------
// Every request walks the stored entries through the single-read-port memory,
// one a cycle.
// Throughput: one request at a time, next accepted after the result is taken.
// Reset: arst_n empties the list; memory contents are not cleared.
module ordered_list_store_top
	import ols_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ols_req_if.sink       req,
	ols_rsp_if.source     rsp
);

	ols_cmd_t cmd;
	ols_sts_t sts;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ols_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_operation     (req.operation),
		.req_value         (req.value),
		.res_status        (rsp.status),
		.res_found         (rsp.found),
		.res_removed_count (rsp.removed_count),
		.res_list_length   (rsp.list_length)
	);

endmodule
